[hdl/assert_macros.svh]
// Assertion macros for the RTL of the voltage select monitor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PDVS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check an implication whose consequent must hold in the next cycle.
`define PDVS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/pdvs_pkg.sv]
// Shared types, constants and functions of the voltage select monitor.
package pdvs_pkg;

   localparam int unsigned SEL_W    = 3;
   localparam int unsigned NUM_SEL  = 5;
   localparam int unsigned ADC_W    = 8;
   localparam int unsigned LED_W    = NUM_SEL;
   localparam int unsigned PERIOD_W = 8;
   localparam int unsigned TICK_W   = 8;
   localparam int unsigned CSR_W    = 8;
   localparam int unsigned REQ_W    = 16;
   localparam int unsigned RSP_W    = 16;

   localparam logic [SEL_W-1:0] SEL_LAST = 3'd4;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd20;

   // configuration register indexes
   localparam logic CSR_INITIAL_SELECTION = 1'b0;
   localparam logic CSR_BLINK_PERIOD      = 1'b1;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [TICK_W-1:0] rem;
   } mod_status_type;

   // Window check: 1 when the sample is outside the selection's window.
   function automatic logic window_fault(input logic [SEL_W-1:0] sel,
                                         input logic [ADC_W-1:0] adc);
      logic [8:0] lo;
      logic [8:0] hi;
      unique case (sel)
         3'd0:    begin lo = 9'd57;  hi = 9'd69;  end
         3'd1:    begin lo = 9'd108; hi = 9'd120; end
         3'd2:    begin lo = 9'd146; hi = 9'd158; end
         3'd3:    begin lo = 9'd184; hi = 9'd197; end
         default: begin lo = 9'd247; hi = 9'd260; end
      endcase
      return !(({1'b0, adc} >= lo) && ({1'b0, adc} <= hi));
   endfunction

   // CFG3..CFG1 drive code of each selection.
   function automatic logic [2:0] pin_code(input logic [SEL_W-1:0] sel);
      logic [2:0] code;
      unique case (sel)
         3'd0:    code = 3'b001;
         3'd1:    code = 3'b000;
         3'd2:    code = 3'b100;
         3'd3:    code = 3'b110;
         default: code = 3'b010;
      endcase
      return code;
   endfunction

   function automatic logic [LED_W-1:0] sel_bit(input logic [SEL_W-1:0] sel);
      return LED_W'(1) << sel;
   endfunction

   // Out-of-range selection codes fold to 5V.
   function automatic logic [SEL_W-1:0] clamp_sel(input logic [SEL_W-1:0] sel);
      return (sel > SEL_LAST) ? '0 : sel;
   endfunction

endpackage

[hdl/pdvs_mod_unit.sv]
// Bit-serial remainder unit: tick count modulo blink period, one bit a cycle.
module pdvs_mod_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [pdvs_pkg::TICK_W-1:0]     dividend,
   input  logic [pdvs_pkg::PERIOD_W-1:0]   divisor,
   output pdvs_pkg::mod_status_type        status
);
   import pdvs_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [2:0]          count_ff, count_in;
   logic [TICK_W-1:0]   rem_ff, rem_in;
   logic [TICK_W-1:0]   dividend_ff, dividend_in;
   logic [PERIOD_W:0]   divisor_ff, divisor_in;
   logic [TICK_W:0]     shifted;

   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      count_in    = count_ff;
      rem_in      = rem_ff;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      shifted     = {rem_ff, dividend_ff[count_ff]};
      if (start) begin
         busy_in     = 1'b1;
         count_in    = 3'd7;
         rem_in      = '0;
         dividend_in = dividend;
         // a zero period counts as 256
         divisor_in  = (divisor == '0) ? 9'd256 : {1'b0, divisor};
      end else if (busy_ff) begin
         // restore step: shift in one dividend bit, subtract when it fits
         if (shifted >= divisor_ff) begin
            rem_in = TICK_W'(shifted - divisor_ff);
         end else begin
            rem_in = shifted[TICK_W-1:0];
         end
         count_in = count_ff - 3'd1;
         if (count_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff      <= rem_in;
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign status.rem  = rem_ff;

endmodule

[hdl/pd_voltage_select_monitor_core.sv]
// Top level of the supply voltage select and monitor block.
//
//   port group | dir | word contents (lowest bit first)
//   -----------+-----+-------------------------------------------------------
//   req_*      | in  | key_level[0], adc_sample[8:1], zero fill
//   rsp_*      | out | selection[2:0], trigger_pins[5:3], led_pattern[10:6],
//              |     | voltage_fault[11], store_request[12], zero fill
//   csr_*      | in  | index 0 initial_selection, index 1 blink_period
//
// One word per cycle unless the input stalls: each accepted poll tick is worked
// out in the cycle it is accepted and loaded into the output register at the
// accepting edge. A blocked output stalls the input only when the output
// register is full. A blink_period write starts a remainder pass (tick count
// modulo the new period, one bit a cycle), and the phase is loaded once it is done;
// req_tready stays low in the write cycle, during the pass and while the phase loads.
// Reset is synchronous and active high; it restores the register defaults.
module pd_voltage_select_monitor_core (
   input  logic                             clock,
   input  logic                             reset,
   // input: key_level, adc_sample
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [pdvs_pkg::REQ_W-1:0]       req_tdata,
   // output: selection, trigger_pins, led_pattern, voltage_fault, store_request
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [pdvs_pkg::RSP_W-1:0]       rsp_tdata,
   input  logic                             csr_we,
   input  logic                             csr_index,
   input  logic [pdvs_pkg::CSR_W-1:0]       csr_wdata
);
   import pdvs_pkg::*;

   `include "assert_macros.svh"

   // tick state
   logic                 prev_key_ff, prev_key_in;
   logic [SEL_W-1:0]     cur_sel_ff, cur_sel_in;
   logic                 blink_en_ff, blink_en_in;
   logic [SEL_W-1:0]     blink_tgt_ff, blink_tgt_in;
   logic [LED_W-1:0]     led_ff, led_in;
   logic [TICK_W-1:0]    tick_ff, tick_in;
   logic [TICK_W-1:0]    phase_ff, phase_in;     // tick count modulo period
   logic [PERIOD_W-1:0]  period_ff, period_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]     rsp_data_ff, rsp_data_in;

   // per-tick logic
   logic                 accept;
   logic                 key;
   logic [ADC_W-1:0]     adc;
   logic                 fall;
   logic [SEL_W-1:0]     sel;
   logic [LED_W-1:0]     led_step;
   logic [LED_W-1:0]     led_check;
   logic                 fault;
   logic [PERIOD_W:0]    period_full;
   logic [TICK_W:0]      phase_inc;

   logic                 mod_start;
   mod_status_type       mod_st;

   // checker terms
   logic                 phase_ok;
   logic                 blink_held;

   assign key = req_tdata[0];
   assign adc = req_tdata[ADC_W:1];

   // stall only on a full output register not being drained, a remainder pass or a csr write
   assign req_tready = (!rsp_valid_ff || rsp_tready) && !mod_st.busy && !mod_st.done
                       && !csr_we;
   assign accept     = req_tvalid && req_tready;

   assign mod_start  = csr_we && (csr_index == CSR_BLINK_PERIOD);

   pdvs_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (tick_ff),
      .divisor  (csr_wdata),
      .status   (mod_st)
   );

   always_comb begin
      prev_key_in  = prev_key_ff;
      cur_sel_in   = cur_sel_ff;
      blink_en_in  = blink_en_ff;
      blink_tgt_in = blink_tgt_ff;
      led_in       = led_ff;
      tick_in      = tick_ff;
      phase_in     = phase_ff;
      period_in    = period_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      // falling key edge: drop the current LED and step the selection
      fall     = prev_key_ff && !key;
      sel      = cur_sel_ff;
      led_step = led_ff;
      if (fall) begin
         led_step = led_ff & ~sel_bit(cur_sel_ff);
         sel      = (cur_sel_ff == SEL_LAST) ? '0 : cur_sel_ff + 3'd1;
      end

      fault     = window_fault(sel, adc);
      led_check = led_step;
      if (!fault) begin
         led_check = led_step | sel_bit(sel);
      end

      // next phase: follow the period, and restart with the 8-bit tick wrap
      period_full = (period_ff == '0) ? 9'd256 : {1'b0, period_ff};
      phase_inc   = {1'b0, phase_ff} + 9'd1;

      if (accept) begin
         prev_key_in  = key;
         cur_sel_in   = sel;
         blink_en_in  = fault;
         blink_tgt_in = fault ? sel : blink_tgt_ff;
         led_in       = led_check;
         // toggle the blinking LED on a phase-zero tick
         if (fault && (phase_ff == '0)) begin
            led_in = led_check ^ sel_bit(sel);
         end else if (!fault) begin
            led_in = led_check;
         end else begin
            led_in = led_check;
         end
         if (!fault) begin
            led_in = led_check;
         end
         tick_in = tick_ff + 8'd1;
         if ((tick_ff == '1) || (phase_inc == period_full)) begin
            phase_in = '0;
         end else begin
            phase_in = phase_inc[TICK_W-1:0];
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({fall, fault, led_in, pin_code(sel), sel});
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INITIAL_SELECTION: cur_sel_in = clamp_sel(csr_wdata[SEL_W-1:0]);
            CSR_BLINK_PERIOD:      period_in  = csr_wdata[PERIOD_W-1:0];
            default:               period_in  = period_ff;
         endcase
      end

      // load the recomputed phase when the remainder pass finishes
      if (mod_st.done) begin
         phase_in = mod_st.rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_key_ff  <= 1'b1;
         cur_sel_ff   <= '0;
         blink_en_ff  <= 1'b0;
         blink_tgt_ff <= '0;
         led_ff       <= '0;
         tick_ff      <= '0;
         phase_ff     <= '0;
         period_ff    <= PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         prev_key_ff  <= prev_key_in;
         cur_sel_ff   <= cur_sel_in;
         blink_en_ff  <= blink_en_in;
         blink_tgt_ff <= blink_tgt_in;
         led_ff       <= led_in;
         tick_ff      <= tick_in;
         phase_ff     <= phase_in;
         period_ff    <= period_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign phase_ok   = mod_st.busy || mod_st.done || (period_ff == '0) ||
                       (phase_ff < period_ff);
   assign blink_held = blink_en_ff && (blink_tgt_ff == cur_sel_ff);

   // phase always below the active period once the remainder pass is settled
   `PDVS_ASSERT(a_phase_range, clock, reset, phase_ok, "phase counter not below blink period")
   // no tick taken while the remainder pass runs
   `PDVS_ASSERT(a_no_accept_busy, clock, reset, !(mod_st.busy && accept), "tick taken while busy")
   // every accepted tick leaves a result in the output register
   `PDVS_ASSERT_NEXT(a_accept_result, clock, reset, accept, rsp_valid_ff, "tick left no result")
   // the blink target follows the selection whenever a fault is seen
   `PDVS_ASSERT_NEXT(a_blink_target, clock, reset, accept && fault, blink_held, "blink target lost")

endmodule

[dv/tb_pd_voltage_select_monitor_core.sv]
// Self-checking testbench for the voltage select and monitor core.
`timescale 1ns / 1ps

module tb_pd_voltage_select_monitor_core;
   import pdvs_pkg::*;

   // Selection codes, lowest supply first.
   typedef enum logic [SEL_W-1:0] {
      SEL_5V  = 3'd0,
      SEL_9V  = 3'd1,
      SEL_12V = 3'd2,
      SEL_15V = 3'd3,
      SEL_20V = 3'd4
   } volt_sel_type;

   // Packed so that the last field lands in the lowest bits of the word.
   typedef struct packed {
      logic [ADC_W-1:0] adc;
      logic             key;
   } poll_tick_type;

   typedef struct packed {
      logic             store;
      logic             fault;
      logic [LED_W-1:0] led;
      logic [2:0]       pins;
      logic [SEL_W-1:0] sel;
   } monitor_word_type;

   localparam int STALL_LIMIT  = 2000; // cycles with no word moving anywhere
   localparam int IDLE_SETTLE  = 12;   // idle wait appended to every drain
   localparam int LONG_HOLD    = 80;   // receiver hold-off that backs up the input
   localparam int DRAIN_AT     = 300;  // sender pauses here until all results are in
   localparam int PHASE_TICKS  = 85;
   localparam int NUM_PHASES   = 7;
   localparam int REPORT_LIMIT = 10;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata = '0;   // key_level, adc_sample, zero fill
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;        // selection, trigger_pins, led_pattern,
                                          // voltage_fault, store_request, zero fill
   logic                csr_we = 1'b0;
   logic                csr_index = CSR_INITIAL_SELECTION;
   logic [CSR_W-1:0]    csr_wdata = '0;

   pd_voltage_select_monitor_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor state: a private copy of the block's registers.
   // ---------------------------------------------------------------------
   logic [SEL_W-1:0]    stored_sel;
   logic [PERIOD_W-1:0] toggle_period;
   logic                last_key;
   volt_sel_type        live_sel;
   logic                blinking;
   volt_sel_type        blink_sel;
   logic [LED_W-1:0]    led_state;
   logic [TICK_W-1:0]   tick_no;

   poll_tick_type    pending_ticks[$];
   monitor_word_type expected_words[$];

   int fail_count = 0;
   int sent_count = 0;

   // Generator shadow of the key and selection, so random samples can aim
   // at the window that the block will actually check.
   logic         gen_last_key = 1'b1;
   volt_sel_type gen_sel = SEL_5V;

   function automatic volt_sel_type next_sel(volt_sel_type s);
      return (s == SEL_20V) ? SEL_5V : volt_sel_type'(s + 1);
   endfunction

   // Inclusive window bounds; the 20V top lies beyond the 8-bit range.
   function automatic logic [8:0] window_low(volt_sel_type s);
      case (s)
         SEL_5V:  return 9'd57;
         SEL_9V:  return 9'd108;
         SEL_12V: return 9'd146;
         SEL_15V: return 9'd184;
         default: return 9'd247;
      endcase
   endfunction

   function automatic logic [8:0] window_high(volt_sel_type s);
      case (s)
         SEL_5V:  return 9'd69;
         SEL_9V:  return 9'd120;
         SEL_12V: return 9'd158;
         SEL_15V: return 9'd197;
         default: return 9'd260;
      endcase
   endfunction

   // CFG3..CFG1 levels for each selection.
   function automatic logic [2:0] drive_code(volt_sel_type s);
      case (s)
         SEL_5V:  return 3'b001;
         SEL_9V:  return 3'b000;
         SEL_12V: return 3'b100;
         SEL_15V: return 3'b110;
         default: return 3'b010;
      endcase
   endfunction

   function automatic void reset_monitor_state();
      stored_sel    = SEL_5V;
      toggle_period = PERIOD_RESET;
      last_key      = 1'b1;
      live_sel      = SEL_5V;
      blinking      = 1'b0;
      blink_sel     = SEL_5V;
      led_state     = '0;
      tick_no       = '0;
   endfunction

   // Mirror a register write; codes above 20V fold back to 5V.
   function automatic void apply_csr(logic idx, logic [CSR_W-1:0] value);
      if (idx == CSR_INITIAL_SELECTION) begin
         stored_sel = (value[SEL_W-1:0] > SEL_20V) ? SEL_5V : value[SEL_W-1:0];
         live_sel   = volt_sel_type'(stored_sel);
      end else begin
         toggle_period = value;
      end
   endfunction

   // Advance the monitor by one poll tick and return the word it must emit.
   function automatic monitor_word_type advance_monitor(poll_tick_type t);
      monitor_word_type w;
      logic             stepped;
      logic             out_of_window;
      int unsigned      span;
      stepped = 1'b0;
      // step only on a press, i.e. a released-to-pressed transition
      if (last_key && !t.key) begin
         led_state = led_state & ~(LED_W'(1) << live_sel);
         live_sel  = next_sel(live_sel);
         stepped   = 1'b1;
      end
      last_key = t.key;
      out_of_window = !(({1'b0, t.adc} >= window_low(live_sel)) &&
                        ({1'b0, t.adc} <= window_high(live_sel)));
      if (!out_of_window) begin
         blinking  = 1'b0;
         led_state = led_state | (LED_W'(1) << live_sel);
      end else begin
         blinking  = 1'b1;
         blink_sel = live_sel;
      end
      // a zero period acts as 256: toggle only when the tick count is zero
      span = (toggle_period == '0) ? 256 : toggle_period;
      if (blinking && ((tick_no % span) == 0))
         led_state = led_state ^ (LED_W'(1) << blink_sel);
      tick_no = tick_no + 1'b1;
      w.sel   = live_sel;
      w.pins  = drive_code(live_sel);
      w.led   = led_state;
      w.fault = out_of_window;
      w.store = stepped;
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_tick(logic key, logic [ADC_W-1:0] adc);
      poll_tick_type t;
      t.key = key;
      t.adc = adc;
      if (gen_last_key && !key)
         gen_sel = next_sel(gen_sel);
      gen_last_key = key;
      pending_ticks.push_back(t);
   endtask

   // Key mostly holds its level for a while; samples mostly hit the window
   // or its edges so both the steady and the blinking paths stay busy.
   task automatic push_random_tick();
      logic             key;
      volt_sel_type     s;
      logic [8:0]       lo;
      logic [8:0]       hi;
      logic [ADC_W-1:0] adc;
      int unsigned      pick;
      key = ($urandom_range(4, 0) == 0) ? ~gen_last_key : gen_last_key;
      s   = (gen_last_key && !key) ? next_sel(gen_sel) : gen_sel;
      lo  = window_low(s);
      hi  = (window_high(s) > 9'd255) ? 9'd255 : window_high(s);
      pick = $urandom_range(99, 0);
      if (pick < 40) begin
         adc = ADC_W'($urandom_range(hi, lo));
      end else if (pick < 65) begin
         case ($urandom_range(3, 0))
            0:       adc = lo[ADC_W-1:0];
            1:       adc = hi[ADC_W-1:0];
            2:       adc = ADC_W'(lo - 9'd1);
            default: adc = (hi == 9'd255) ? 8'd255 : ADC_W'(hi + 9'd1);
         endcase
      end else begin
         adc = ADC_W'($urandom_range(255, 0));
      end
      push_tick(key, adc);
   endtask

   // Write one register at a clock edge and mirror it in the predictor.
   task automatic write_reg(logic idx, logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      apply_csr(idx, value);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Hold until every queued tick went in and every result came out.
   task automatic wait_drained();
      while (pending_ticks.size() != 0 || req_tvalid || expected_words.size() != 0)
         @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Driver: feed pending ticks in bursts with random gaps.
   // ---------------------------------------------------------------------
   poll_tick_type on_bus;
   int            burst_left = 0;
   int            gap_left   = 0;
   logic          draining   = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_words.push_back(advance_monitor(on_bus));
            sent_count++;
            if (sent_count == DRAIN_AT)
               draining = 1'b1;
         end
         if (draining && expected_words.size() == 0)
            draining = 1'b0;
         // change the offered word only when none is waiting
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (draining || pending_ticks.size() == 0) begin
               req_tvalid <= 1'b0;
            end else begin
               on_bus = pending_ticks.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_W'(on_bus);
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(24, 1);
                  gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: check each result word and stall on a pattern of its own.
   // ---------------------------------------------------------------------
   logic        long_hold_req  = 1'b0;
   logic        long_hold_done = 1'b0;
   int          hold_left  = 0;
   int          mode_left  = 0;
   int unsigned stall_mode = 0;

   always @(posedge clock) begin
      monitor_word_type got;
      monitor_word_type want;
      logic             ready;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = monitor_word_type'(rsp_tdata[$bits(monitor_word_type)-1:0]);
            if (expected_words.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("unexpected result word %h", rsp_tdata);
            end else begin
               want = expected_words.pop_front();
               if (got.sel !== want.sel || got.pins !== want.pins ||
                   got.led !== want.led || got.fault !== want.fault ||
                   got.store !== want.store) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display({"word mismatch: sel %0d/%0d pins %b/%b led %b/%b ",
                               "fault %b/%b store %b/%b (exp/got)"},
                              want.sel, got.sel, want.pins, got.pins, want.led, got.led,
                              want.fault, got.fault, want.store, got.store);
               end
            end
         end
         // one long hold-off so the output register fills and the input stalls
         if (long_hold_req && !long_hold_done) begin
            hold_left      = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(3, 0);
               mode_left  = $urandom_range(80, 10);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               0:       ready = 1'b1;
               1:       ready = 1'($urandom_range(1, 0));
               2:       ready = ($urandom_range(3, 0) == 0);
               default: ready = ($urandom_range(7, 0) != 0);
            endcase
            rsp_tready <= ready;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: end the run if no word moves for too long.
   // ---------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("pd_voltage_select_monitor_core: mismatch");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequence: directed ticks, then random phases under several settings.
   // ---------------------------------------------------------------------
   logic [CSR_W-1:0] phase_sel[NUM_PHASES];
   logic [CSR_W-1:0] phase_period[NUM_PHASES];

   initial begin
      // selection codes 5..7 must fold to 5V; periods cover 1, 0 (as 256) and 255
      phase_sel    = '{8'd4, 8'd7, 8'd2, 8'd5, 8'hFB, 8'd1, 8'd6};
      phase_period = '{8'd1, 8'd0, 8'd255, 8'd2, 8'd7, 8'd20, 8'd128};
      reset_monitor_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // 5V window edges and extremes of the sample
      push_tick(1'b1, 8'd57);
      push_tick(1'b1, 8'd69);
      push_tick(1'b1, 8'd56);
      push_tick(1'b1, 8'd70);
      push_tick(1'b1, 8'd0);
      push_tick(1'b1, 8'd255);
      // walk through every selection by presses, with held and released key
      push_tick(1'b0, 8'd108);
      push_tick(1'b0, 8'd120);
      push_tick(1'b1, 8'd107);
      push_tick(1'b0, 8'd121);
      push_tick(1'b1, 8'd146);
      push_tick(1'b0, 8'd158);
      push_tick(1'b1, 8'd184);
      push_tick(1'b1, 8'd197);
      push_tick(1'b0, 8'd247);
      push_tick(1'b1, 8'd255);
      push_tick(1'b1, 8'd246);
      // wrap from 20V back to 5V
      push_tick(1'b0, 8'd0);
      push_tick(1'b1, 8'd69);
      push_tick(1'b1, 8'd64);
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_reg(CSR_BLINK_PERIOD, phase_period[p]);
         write_reg(CSR_INITIAL_SELECTION, phase_sel[p]);
         gen_sel = (phase_sel[p][SEL_W-1:0] > SEL_20V) ? SEL_5V
                                                       : volt_sel_type'(phase_sel[p][SEL_W-1:0]);
         if (p == 2)
            long_hold_req = 1'b1;
         for (int i = 0; i < PHASE_TICKS; i++)
            push_random_tick();
         wait_drained();
      end

      if (fail_count == 0 && expected_words.size() == 0) begin
         $display("pd_voltage_select_monitor_core: match");
      end else begin
         $display("pd_voltage_select_monitor_core: mismatch");
      end
      $finish;
   end

endmodule
